@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the matcher modules.
// Each use expands to one labeled concurrent assertion on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge outside reset
`define WGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check the cycle after a reset edge
`define WGM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> prop) \
        else $error(msg);

`endif

@@ design/wgm_pkg.sv @@
// ----------------------------------------------------------------------------
// wgm_pkg
// Types and constants shared by the wildcard matcher modules.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int CHAR_BITS         = 8;
    localparam int PATTERN_DEPTH_DEF = 32;

    localparam logic [CHAR_BITS-1:0] STAR_CODE  = 8'd42;
    localparam logic [CHAR_BITS-1:0] QMARK_CODE = 8'd63;

    // req_type codes
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_NAME    = 1'b1;

    // one classified word, front to back
    typedef struct packed {
        logic                 is_name;
        logic                 new_seq;
        logic                 char_valid;
        logic                 final_char;
        logic [CHAR_BITS-1:0] char_code;
    } t_cmd;

endpackage

@@ design/wgm_req_if.sv @@
// ----------------------------------------------------------------------------
// wgm_req_if
// Request channel: pattern and name characters with valid/ready.
// ----------------------------------------------------------------------------
interface wgm_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [wgm_pkg::CHAR_BITS-1:0] char_code;
    logic                          char_valid;
    logic                          final_char;

    modport source (output valid, req_type, char_code, char_valid, final_char,
                    input ready);
    modport sink   (input valid, req_type, char_code, char_valid, final_char,
                    output ready);
endinterface

@@ design/wgm_res_if.sv @@
// ----------------------------------------------------------------------------
// wgm_res_if
// Result channel: match verdict per completed name with valid/ready.
// ----------------------------------------------------------------------------
interface wgm_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, matched, pattern_overflow, input ready);
    modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

@@ design/wgm_fifo.sv @@
// ----------------------------------------------------------------------------
// wgm_fifo
// Two-slot command queue between the front and back of the matcher.
// ----------------------------------------------------------------------------
module wgm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wgm_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output wgm_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    wgm_pkg::t_cmd r_slot0, n_slot0;
    wgm_pkg::t_cmd r_slot1, n_slot1;
    logic [1:0]    r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot0;

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_count = r_count;
        unique case ({i_push, i_pop})
            2'b11: begin
                if (r_count == 2'd1) begin
                    n_slot0 = i_cmd;
                end else begin
                    n_slot0 = r_slot1;
                    n_slot1 = i_cmd;
                end
            end
            2'b10: begin
                if (r_count == 2'd0) begin
                    n_slot0 = i_cmd;
                end else begin
                    n_slot1 = i_cmd;
                end
                n_count = r_count + 2'd1;
            end
            2'b01: begin
                n_slot0 = r_slot1;
                n_count = r_count - 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

@@ design/wgm_front.sv @@
// ----------------------------------------------------------------------------
// wgm_front
// Accepts request words and tags each one as the start or continuation of a
// pattern or a name.
// ----------------------------------------------------------------------------
module wgm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wgm_req_if.sink       i_req,
    input  logic          i_full,
    output logic          o_push,
    output wgm_pkg::t_cmd o_cmd
);

    logic r_pat_open,  n_pat_open;
    logic r_name_open, n_name_open;
    logic is_name;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;
    assign is_name     = (i_req.req_type == wgm_pkg::REQ_NAME);

    always_comb begin
        o_cmd.is_name    = is_name;
        o_cmd.new_seq    = is_name ? !r_name_open : !r_pat_open;
        o_cmd.char_valid = i_req.char_valid;
        o_cmd.final_char = i_req.final_char;
        o_cmd.char_code  = i_req.char_code;
    end

    always_comb begin
        n_pat_open  = r_pat_open;
        n_name_open = r_name_open;
        if (o_push) begin
            // a pattern word drops any open name; a name word closes the pattern
            if (is_name) begin
                n_pat_open  = 1'b0;
                n_name_open = !i_req.final_char;
            end else begin
                n_pat_open  = !i_req.final_char;
                n_name_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_open  <= 1'b0;
            r_name_open <= 1'b0;
        end else begin
            r_pat_open  <= n_pat_open;
            r_name_open <= n_name_open;
        end
    end

endmodule

@@ design/wgm_back.sv @@
// ----------------------------------------------------------------------------
// wgm_back
// Holds the pattern and the set of live positions, executes one queued
// word per cycle unless a verdict waits, registers each name's verdict.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wgm_back #(
    parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wgm_pkg::t_cmd i_cmd,
    output logic          o_pop,
    wgm_res_if.source     o_res
);

    localparam int LW = $clog2(PATTERN_DEPTH + 1);
    localparam int IW = $clog2(PATTERN_DEPTH);
    localparam int PW = PATTERN_DEPTH + 1;

    logic [wgm_pkg::CHAR_BITS-1:0] r_char [PATTERN_DEPTH];

    logic [LW-1:0]            r_len,    n_len;
    logic [PW-1:0]            r_len_oh, n_len_oh;
    logic [PATTERN_DEPTH-1:0] r_mask,   n_mask;
    logic                     r_ovf,    n_ovf;
    logic [PW-1:0]            r_start,  n_start;
    logic [PW-1:0]            r_active, n_active;
    logic                     r_out_valid, n_out_valid;
    logic                     r_matched,   n_matched;
    logic                     r_povf,      n_povf;

    logic                     emits;
    logic                     wr_en;
    logic                     room;
    logic                     c_star;
    logic [PATTERN_DEPTH-1:0] is_star;
    logic [PATTERN_DEPTH-1:0] is_hit;
    logic [PW-1:0]            base_act;
    logic [PW-1:0]            stay;
    logic [PW-1:0]            adv;
    logic [PW-1:0]            raw;
    logic [PW-1:0]            closed;
    logic [PW-1:0]            stepped;
    logic                     hit;
    logic [LW-1:0]            len_b;
    logic [PW-1:0]            oh_b;
    logic [PATTERN_DEPTH-1:0] mask_b;
    logic [PW-1:0]            start_b;
    logic                     ovf_b;

    assign emits = i_cmd.is_name && i_cmd.final_char;
    // hold a final name word while a verdict still waits downstream
    assign o_pop = i_valid && (!emits || !r_out_valid || o_res.ready);

    assign o_res.valid            = r_out_valid;
    assign o_res.matched          = r_matched;
    assign o_res.pattern_overflow = r_povf;

    // ---- name step: advance every live position on one character ----
    assign base_act = i_cmd.new_seq ? r_start : r_active;

    always_comb begin
        stay = '0;
        adv  = '0;
        for (int i = 0; i < PATTERN_DEPTH; i++) begin
            is_star[i] = r_mask[i] && (r_char[i] == wgm_pkg::STAR_CODE);
            is_hit[i]  = (r_char[i] == wgm_pkg::QMARK_CODE)
                      || (r_char[i] == i_cmd.char_code);
            if (base_act[i] && r_mask[i]) begin
                if (is_star[i]) begin
                    stay[i] = 1'b1;
                end else if (is_hit[i]) begin
                    adv[i + 1] = 1'b1;
                end
            end
        end
    end

    assign raw = stay | adv;

    // let a live position in front of a star also light the next one
    always_comb begin
        closed[0] = raw[0];
        for (int i = 0; i < PATTERN_DEPTH; i++) begin
            closed[i + 1] = raw[i + 1] || (closed[i] && is_star[i]);
        end
    end

    assign stepped = i_cmd.char_valid ? closed : base_act;
    assign hit     = (|(stepped & r_len_oh)) && !r_ovf;

    // ---- pattern load ----
    assign len_b   = i_cmd.new_seq ? '0 : r_len;
    assign oh_b    = i_cmd.new_seq ? PW'(1) : r_len_oh;
    assign mask_b  = i_cmd.new_seq ? '0 : r_mask;
    assign start_b = i_cmd.new_seq ? PW'(1) : r_start;
    assign ovf_b   = i_cmd.new_seq ? 1'b0 : r_ovf;
    assign room    = (len_b != LW'(PATTERN_DEPTH));
    assign c_star  = (i_cmd.char_code == wgm_pkg::STAR_CODE);
    assign wr_en   = o_pop && !i_cmd.is_name && i_cmd.char_valid && room;

    always_comb begin
        n_len       = r_len;
        n_len_oh    = r_len_oh;
        n_mask      = r_mask;
        n_ovf       = r_ovf;
        n_start     = r_start;
        n_active    = r_active;
        n_out_valid = r_out_valid && !o_res.ready;
        n_matched   = r_matched;
        n_povf      = r_povf;
        if (o_pop) begin
            if (i_cmd.is_name) begin
                if (i_cmd.final_char) begin
                    n_out_valid = 1'b1;
                    n_matched   = hit;
                    n_povf      = r_ovf;
                    n_active    = r_start;
                end else begin
                    n_active    = stepped;
                end
            end else begin
                n_len    = len_b;
                n_len_oh = oh_b;
                n_mask   = mask_b;
                n_ovf    = ovf_b;
                n_start  = start_b;
                if (i_cmd.char_valid) begin
                    if (room) begin
                        n_len    = len_b + LW'(1);
                        n_len_oh = oh_b << 1;
                        n_mask   = mask_b | oh_b[PATTERN_DEPTH-1:0];
                        // leading stars extend the start set
                        if (c_star) begin
                            n_start = start_b | ((start_b & oh_b) << 1);
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_active = n_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_char[len_b[IW-1:0]] <= i_cmd.char_code;
        end
        r_matched <= n_matched;
        r_povf    <= n_povf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_len_oh    <= PW'(1);
            r_mask      <= '0;
            r_ovf       <= 1'b0;
            r_start     <= PW'(1);
            r_active    <= PW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_len_oh    <= n_len_oh;
            r_mask      <= n_mask;
            r_ovf       <= n_ovf;
            r_start     <= n_start;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    `WGM_ASSERT(a_ovf_full, r_ovf |-> (r_len == LW'(PATTERN_DEPTH)), "overflow below capacity")
    `WGM_ASSERT(a_len_oh, r_len_oh[r_len] && $onehot(r_len_oh), "length marker out of step")
    `WGM_ASSERT(a_emit, (o_pop && emits) |=> r_out_valid, "finished name gave no verdict")
    `WGM_ASSERT_RST(a_rst, (r_len == '0) && (r_active == PW'(1)) && !r_out_valid, "bad reset state")

endmodule

@@ design/wildcard_glob_matcher.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Glob matcher with a stored pattern: '*' any run, '?' one character.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries words: req_type selects pattern (load) or name (match),
//   char_valid=0 carries no character, final_char closes the pattern or name.
//   Load a pattern one character per word, then stream names one character
//   per word. o_res gives one word per finished name: matched, and
//   pattern_overflow when the pattern ran past PATTERN_DEPTH characters
//   (matched is then 0).
// Throughput: one word per cycle on i_req unless a held verdict stalls it,
//   set by the front-to-back queue and the back end, which updates all
//   pattern positions at once.
// Path: a final name word passes the queue, then the match stage register.
// Reset: empty pattern, no open pattern or name; an empty pattern matches
//   only an empty name.
// Stall: the verdict holds in the output register while o_res.ready is low;
//   a following final name word waits at the queue head, other words keep
//   moving, and once the two-slot queue fills i_req.ready drops.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
    parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wgm_req_if.sink   i_req,
    wgm_res_if.source o_res
);

    wgm_pkg::t_cmd push_cmd;
    wgm_pkg::t_cmd head_cmd;
    logic          push;
    logic          full;
    logic          head_valid;
    logic          pop;

    wgm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    wgm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    wgm_back #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
